// File: hw/rtl/lpt_pkg.sv
// Shared types and fixed-point widths for the laser pixel triangulation block.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package lpt_pkg;

    // register index map of the configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd7;

    localparam int PIX_W  = 12;    // pixel coordinate ports
    localparam int UC_W   = 16;    // coordinate after masking, widest COORD_BITS
    localparam int CH_W   = 8;
    localparam int BND_W  = 24;
    localparam int INV_W  = 24;
    localparam int CTR_W  = 16;
    localparam int NRM_W  = 16;    // one normal component, Q1.14
    localparam int OFS_W  = 32;
    localparam int DU_W   = 21;    // 16*u - cx, signed Q.4
    localparam int X_W    = 45;    // ray direction, signed Q.28
    localparam int T_W    = 61;    // one normal product
    localparam int D_W    = 63;    // denominator, signed Q.42
    localparam int PLO_W  = 23;    // low slice of |X| for the split product
    localparam int P_W    = 76;    // |d| * |N|
    localparam int M_W    = 90;    // dividend |d| * |N| * 2^14
    localparam int Q_W    = 33;    // quotient bits kept beyond the overflow test
    localparam int R_W    = 63;    // remainder, always below the divisor
    localparam int LANES  = 3;
    localparam int OUT_W  = 32;

    localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [BND_W-1:0]     RST_LOWER  = 24'hFF25A6;
    localparam logic [BND_W-1:0]     RST_UPPER  = 24'hFFFFFF;
    localparam logic [INV_W-1:0]     RST_INV_F  = 24'd27962;
    localparam logic [CTR_W-1:0]     RST_CX     = 16'd5120;
    localparam logic [CTR_W-1:0]     RST_CY     = 16'd3840;
    localparam logic [3*NRM_W-1:0]   RST_NORMAL = 48'h4000_0000_0000;
    localparam logic [OFS_W-1:0]     RST_OFFSET = 32'hFFFF_0000;

    // per-item flags that ride along the divider
    typedef struct packed {
        logic             par;      // denominator zero
        logic [LANES-1:0] neg;      // quotient sign
        logic [LANES-1:0] nz;       // numerator nonzero
        logic [LANES-1:0] to_max;   // -d*N positive
    } t_ctl;

    // one coordinate lane of the restoring divider
    typedef struct packed {
        logic             ovf;
        logic [Q_W-1:0]   m;
        logic [R_W-1:0]   rem;
        logic [Q_W-1:0]   q;
    } t_lane;

endpackage

// File: hw/rtl/lpt_front.sv
// Front stages: channel band test, principal point offset and inverse focal scaling.
// Depends on lpt_pkg.
module lpt_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic [lpt_pkg::PIX_W-1:0]         i_pixel_column,
    input  logic [lpt_pkg::PIX_W-1:0]         i_pixel_row,
    input  logic [lpt_pkg::CH_W-1:0]          i_channel_zero,
    input  logic [lpt_pkg::CH_W-1:0]          i_channel_one,
    input  logic [lpt_pkg::CH_W-1:0]          i_channel_two,
    input  logic [lpt_pkg::BND_W-1:0]         i_lower,
    input  logic [lpt_pkg::BND_W-1:0]         i_upper,
    input  logic [lpt_pkg::INV_W-1:0]         i_inv_fx,
    input  logic [lpt_pkg::INV_W-1:0]         i_inv_fy,
    input  logic [lpt_pkg::CTR_W-1:0]         i_cx,
    input  logic [lpt_pkg::CTR_W-1:0]         i_cy,
    input  logic                              i_offset_zero,
    output logic                              o_valid,
    output logic signed [lpt_pkg::X_W-1:0]    o_x,
    output logic signed [lpt_pkg::X_W-1:0]    o_y
);
    localparam logic [lpt_pkg::UC_W-1:0] COORD_MASK =
        lpt_pkg::UC_W'((33'd1 << COORD_BITS) - 33'd1);

    logic [lpt_pkg::UC_W-1:0]            u_m, v_m;
    logic                                in_band;
    logic signed [lpt_pkg::DU_W-1:0]     n_du, n_dv;
    logic signed [lpt_pkg::X_W:0]        n_x, n_y;
    logic                                r_v1, r_v2;
    logic signed [lpt_pkg::DU_W-1:0]     r_du, r_dv;
    logic signed [lpt_pkg::X_W-1:0]      r_x, r_y;

    assign u_m = {4'b0, i_pixel_column} & COORD_MASK;
    assign v_m = {4'b0, i_pixel_row} & COORD_MASK;

    assign in_band = (i_channel_zero >= i_lower[7:0])   && (i_channel_zero <= i_upper[7:0])
                  && (i_channel_one  >= i_lower[15:8])  && (i_channel_one  <= i_upper[15:8])
                  && (i_channel_two  >= i_lower[23:16]) && (i_channel_two  <= i_upper[23:16]);

    assign n_du = $signed({1'b0, u_m, 4'b0}) - $signed({5'b0, i_cx});
    assign n_dv = $signed({1'b0, v_m, 4'b0}) - $signed({5'b0, i_cy});
    assign n_x  = r_du * $signed({1'b0, i_inv_fx});
    assign n_y  = r_dv * $signed({1'b0, i_inv_fy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            // drop pixels outside the band and everything while the plane hits the centre
            r_v1 <= i_valid && in_band && !i_offset_zero;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_du <= n_du;
            r_dv <= n_dv;
            r_x  <= n_x[lpt_pkg::X_W-1:0];
            r_y  <= n_y[lpt_pkg::X_W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x;
    assign o_y     = r_y;
endmodule

// File: hw/rtl/lpt_plane.sv
// Plane stages: denominator, split dividend products, magnitudes and overflow test.
// Depends on lpt_pkg; feeds lpt_div.
module lpt_plane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  logic signed [lpt_pkg::X_W-1:0]         i_x,
    input  logic signed [lpt_pkg::X_W-1:0]         i_y,
    input  logic [3*lpt_pkg::NRM_W-1:0]            i_normal,
    input  logic [lpt_pkg::OFS_W-1:0]              i_offset,
    output logic                                   o_valid,
    output lpt_pkg::t_ctl                          o_ctl,
    output logic [lpt_pkg::R_W-1:0]                o_div,
    output lpt_pkg::t_lane [lpt_pkg::LANES-1:0]    o_lane
);
    localparam int PL_W = lpt_pkg::OFS_W + lpt_pkg::PLO_W;
    localparam int PH_W = lpt_pkg::OFS_W + lpt_pkg::X_W - lpt_pkg::PLO_W;

    logic signed [lpt_pkg::NRM_W-1:0]  na, nb, nc;
    logic                              sd, sx, sy;
    logic [lpt_pkg::OFS_W-1:0]         d_mag;
    logic [lpt_pkg::X_W-1:0]           x_mag, y_mag;
    logic signed [lpt_pkg::T_W-1:0]    n_ta, n_tb, n_tc;
    logic signed [lpt_pkg::D_W-1:0]    n_den;
    logic [lpt_pkg::P_W-1:0]           n_px, n_py;
    logic [lpt_pkg::M_W-1:0]           hi_ext [lpt_pkg::LANES];

    // stage 3
    logic                              r_v3, r_sd3, r_sx3, r_sy3, r_nzx3, r_nzy3;
    logic signed [lpt_pkg::T_W-1:0]    r_ta, r_tb, r_tc;
    logic [PL_W-1:0]                   r_pxl, r_pyl;
    logic [PH_W-1:0]                   r_pxh, r_pyh;
    logic [lpt_pkg::OFS_W-1:0]         r_dmag;
    // stage 4
    logic                              r_v4, r_sd4, r_sx4, r_sy4, r_nzx4, r_nzy4;
    logic signed [lpt_pkg::D_W-1:0]    r_den;
    logic [lpt_pkg::M_W-1:0]           r_m4 [lpt_pkg::LANES];
    // stage 5
    logic                              r_v5;
    lpt_pkg::t_ctl                     r_ctl5;
    logic [lpt_pkg::R_W-1:0]           r_div5;
    logic [lpt_pkg::M_W-1:0]           r_m5 [lpt_pkg::LANES];
    // stage 6
    logic                              r_v6;
    lpt_pkg::t_ctl                     r_ctl6;
    logic [lpt_pkg::R_W-1:0]           r_div6;
    lpt_pkg::t_lane [lpt_pkg::LANES-1:0] r_lane6;

    assign na = $signed(i_normal[15:0]);
    assign nb = $signed(i_normal[31:16]);
    assign nc = $signed(i_normal[47:32]);
    assign sd = i_offset[lpt_pkg::OFS_W-1];
    assign sx = i_x[lpt_pkg::X_W-1];
    assign sy = i_y[lpt_pkg::X_W-1];
    assign d_mag = sd ? (~i_offset + 32'd1) : i_offset;
    assign x_mag = sx ? lpt_pkg::X_W'(-i_x) : lpt_pkg::X_W'(i_x);
    assign y_mag = sy ? lpt_pkg::X_W'(-i_y) : lpt_pkg::X_W'(i_y);

    assign n_ta = na * i_x;
    assign n_tb = nb * i_y;
    assign n_tc = {{(lpt_pkg::T_W - lpt_pkg::NRM_W - 28){nc[lpt_pkg::NRM_W-1]}}, nc, 28'b0};

    assign n_den = lpt_pkg::D_W'(r_ta) + lpt_pkg::D_W'(r_tb) + lpt_pkg::D_W'(r_tc);
    assign n_px  = lpt_pkg::P_W'(r_pxl) + (lpt_pkg::P_W'(r_pxh) << lpt_pkg::PLO_W);
    assign n_py  = lpt_pkg::P_W'(r_pyl) + (lpt_pkg::P_W'(r_pyh) << lpt_pkg::PLO_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_adv) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_comb begin
        for (int l = 0; l < lpt_pkg::LANES; l++) begin
            hi_ext[l] = r_m5[l] >> lpt_pkg::Q_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ta   <= n_ta;
            r_tb   <= n_tb;
            r_tc   <= n_tc;
            r_pxl  <= d_mag * x_mag[lpt_pkg::PLO_W-1:0];
            r_pxh  <= d_mag * x_mag[lpt_pkg::X_W-1:lpt_pkg::PLO_W];
            r_pyl  <= d_mag * y_mag[lpt_pkg::PLO_W-1:0];
            r_pyh  <= d_mag * y_mag[lpt_pkg::X_W-1:lpt_pkg::PLO_W];
            r_dmag <= d_mag;
            r_sd3  <= sd;
            r_sx3  <= sx;
            r_sy3  <= sy;
            r_nzx3 <= (i_x != '0);
            r_nzy3 <= (i_y != '0);

            r_den  <= n_den;
            r_m4[0] <= {n_px, 14'b0};
            r_m4[1] <= {n_py, 14'b0};
            r_m4[2] <= lpt_pkg::M_W'({r_dmag, 42'b0});
            r_sd4  <= r_sd3;
            r_sx4  <= r_sx3;
            r_sy4  <= r_sy3;
            r_nzx4 <= r_nzx3;
            r_nzy4 <= r_nzy3;

            r_div5 <= r_den[lpt_pkg::D_W-1] ? lpt_pkg::R_W'(-r_den) : lpt_pkg::R_W'(r_den);
            r_ctl5.par    <= (r_den == '0);
            // -d*N/den is negative when d, N and den carry an even number of minus signs
            r_ctl5.neg    <= ~{r_sd4 ^ r_den[lpt_pkg::D_W-1],
                               r_sd4 ^ r_sy4 ^ r_den[lpt_pkg::D_W-1],
                               r_sd4 ^ r_sx4 ^ r_den[lpt_pkg::D_W-1]};
            r_ctl5.nz     <= {1'b1, r_nzy4, r_nzx4};
            r_ctl5.to_max <= {r_sd4, r_sd4 ^ r_sy4, r_sd4 ^ r_sx4};
            r_m5   <= r_m4;

            r_div6 <= r_div5;
            r_ctl6 <= r_ctl5;
            for (int l = 0; l < lpt_pkg::LANES; l++) begin
                // quotient at or above 2^Q_W saturates; otherwise the top part stays below divisor
                r_lane6[l].ovf <= (hi_ext[l] >= lpt_pkg::M_W'(r_div5));
                r_lane6[l].rem <= hi_ext[l][lpt_pkg::R_W-1:0];
                r_lane6[l].m   <= r_m5[l][lpt_pkg::Q_W-1:0];
                r_lane6[l].q   <= '0;
            end
        end
    end

    assign o_valid = r_v6;
    assign o_ctl   = r_ctl6;
    assign o_div   = r_div6;
    assign o_lane  = r_lane6;
endmodule

// File: hw/rtl/lpt_div.sv
// Pipelined restoring divider, one quotient bit per stage for three lanes.
// Depends on lpt_pkg; driven by lpt_plane.
module lpt_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  logic                                   i_valid,
    input  lpt_pkg::t_ctl                          i_ctl,
    input  logic [lpt_pkg::R_W-1:0]                i_div,
    input  lpt_pkg::t_lane [lpt_pkg::LANES-1:0]    i_lane,
    output logic                                   o_valid,
    output lpt_pkg::t_ctl                          o_ctl,
    output lpt_pkg::t_lane [lpt_pkg::LANES-1:0]    o_lane
);
    logic                                  r_v    [lpt_pkg::Q_W];
    lpt_pkg::t_ctl                         r_ctl  [lpt_pkg::Q_W];
    logic [lpt_pkg::R_W-1:0]               r_div  [lpt_pkg::Q_W];
    lpt_pkg::t_lane [lpt_pkg::LANES-1:0]   r_lane [lpt_pkg::Q_W];

    for (genvar k = 0; k < lpt_pkg::Q_W; k++) begin : g_step
        logic                                  v_in;
        lpt_pkg::t_ctl                         c_in;
        logic [lpt_pkg::R_W-1:0]               d_in;
        lpt_pkg::t_lane [lpt_pkg::LANES-1:0]   l_in, l_out;
        logic [lpt_pkg::R_W:0]                 trial [lpt_pkg::LANES];
        logic [lpt_pkg::R_W:0]                 diff  [lpt_pkg::LANES];

        if (k == 0) begin : g_head
            assign v_in = i_valid;
            assign c_in = i_ctl;
            assign d_in = i_div;
            assign l_in = i_lane;
        end else begin : g_body
            assign v_in = r_v[k-1];
            assign c_in = r_ctl[k-1];
            assign d_in = r_div[k-1];
            assign l_in = r_lane[k-1];
        end

        always_comb begin
            for (int l = 0; l < lpt_pkg::LANES; l++) begin
                trial[l] = {l_in[l].rem, l_in[l].m[lpt_pkg::Q_W-1-k]};
                diff[l]  = trial[l] - {1'b0, d_in};
                l_out[l] = l_in[l];
                // subtract when the shifted remainder covers the divisor
                if (trial[l] >= {1'b0, d_in}) begin
                    l_out[l].rem = diff[l][lpt_pkg::R_W-1:0];
                    l_out[l].q   = {l_in[l].q[lpt_pkg::Q_W-2:0], 1'b1};
                end else begin
                    l_out[l].rem = trial[l][lpt_pkg::R_W-1:0];
                    l_out[l].q   = {l_in[l].q[lpt_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_ctl[k]  <= c_in;
                r_div[k]  <= d_in;
                r_lane[k] <= l_out;
            end
        end
    end

    assign o_valid = r_v[lpt_pkg::Q_W-1];
    assign o_ctl   = r_ctl[lpt_pkg::Q_W-1];
    assign o_lane  = r_lane[lpt_pkg::Q_W-1];
endmodule

// File: hw/rtl/laser_pixel_triangulation.sv
// Top level of the laser pixel triangulation block: configuration registers,
// stage wiring and output saturation. Depends on lpt_pkg, lpt_front, lpt_plane, lpt_div.
//
// Usage:
//   Input channel: i_in_valid with pixel column, row and three channel values;
//   a pixel transfers at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid with point_x/y/z (Q16.16) and status; a result
//   transfers at an edge with o_out_valid high and i_out_stall low.
//   Pixels outside the channel band, and all pixels while the plane offset is
//   zero, produce no result; every other pixel produces exactly one.
//   From input transfer to o_out_valid a pixel passes two front stages,
//   four plane stages, 33 divider stages (one quotient bit per stage) and the
//   output register. Throughput is one pixel per cycle unless the output stalls.
//   A stall at the output freezes the whole pipeline together with the output
//   register; o_in_stall is high exactly while a result waits stalled.
//   Reset (synchronous, active low) empties the pipeline and loads the default
//   camera intrinsics, band and plane. Configuration is written through
//   i_cfg_we/i_cfg_index/i_cfg_data with no handshake and takes effect at once.
module laser_pixel_triangulation #(
    parameter int COORD_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lpt_pkg::PIX_W-1:0]            i_pixel_column,
    input  logic [lpt_pkg::PIX_W-1:0]            i_pixel_row,
    input  logic [lpt_pkg::CH_W-1:0]             i_channel_zero,
    input  logic [lpt_pkg::CH_W-1:0]             i_channel_one,
    input  logic [lpt_pkg::CH_W-1:0]             i_channel_two,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lpt_pkg::OUT_W-1:0]     o_point_x,
    output logic signed [lpt_pkg::OUT_W-1:0]     o_point_y,
    output logic signed [lpt_pkg::OUT_W-1:0]     o_point_z,
    output logic                                 o_status,
    input  logic                                 i_cfg_we,
    input  logic [lpt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lpt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    logic [lpt_pkg::BND_W-1:0]         r_lower, r_upper;
    logic [lpt_pkg::INV_W-1:0]         r_inv_fx, r_inv_fy;
    logic [lpt_pkg::CTR_W-1:0]         r_cx, r_cy;
    logic [3*lpt_pkg::NRM_W-1:0]       r_normal;
    logic [lpt_pkg::OFS_W-1:0]         r_offset;

    logic                              adv;
    logic                              f_valid, p_valid, d_valid;
    logic signed [lpt_pkg::X_W-1:0]    f_x, f_y;
    lpt_pkg::t_ctl                     p_ctl, d_ctl;
    logic [lpt_pkg::R_W-1:0]           p_div;
    lpt_pkg::t_lane [lpt_pkg::LANES-1:0] p_lane, d_lane;
    logic [lpt_pkg::OUT_W-1:0]         n_res [lpt_pkg::LANES];

    logic                              r_out_valid, r_status;
    logic [lpt_pkg::OUT_W-1:0]         r_px, r_py, r_pz;

    // advance everything unless a finished result is held by the receiver
    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= lpt_pkg::RST_LOWER;
            r_upper  <= lpt_pkg::RST_UPPER;
            r_inv_fx <= lpt_pkg::RST_INV_F;
            r_inv_fy <= lpt_pkg::RST_INV_F;
            r_cx     <= lpt_pkg::RST_CX;
            r_cy     <= lpt_pkg::RST_CY;
            r_normal <= lpt_pkg::RST_NORMAL;
            r_offset <= lpt_pkg::RST_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpt_pkg::CFG_LOWER:  r_lower  <= i_cfg_data[lpt_pkg::BND_W-1:0];
                lpt_pkg::CFG_UPPER:  r_upper  <= i_cfg_data[lpt_pkg::BND_W-1:0];
                lpt_pkg::CFG_INV_FX: r_inv_fx <= i_cfg_data[lpt_pkg::INV_W-1:0];
                lpt_pkg::CFG_INV_FY: r_inv_fy <= i_cfg_data[lpt_pkg::INV_W-1:0];
                lpt_pkg::CFG_CX:     r_cx     <= i_cfg_data[lpt_pkg::CTR_W-1:0];
                lpt_pkg::CFG_CY:     r_cy     <= i_cfg_data[lpt_pkg::CTR_W-1:0];
                lpt_pkg::CFG_NORMAL: r_normal <= i_cfg_data[3*lpt_pkg::NRM_W-1:0];
                lpt_pkg::CFG_OFFSET: r_offset <= i_cfg_data[lpt_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    lpt_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_valid        (i_in_valid),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_channel_zero (i_channel_zero),
        .i_channel_one  (i_channel_one),
        .i_channel_two  (i_channel_two),
        .i_lower        (r_lower),
        .i_upper        (r_upper),
        .i_inv_fx       (r_inv_fx),
        .i_inv_fy       (r_inv_fy),
        .i_cx           (r_cx),
        .i_cy           (r_cy),
        .i_offset_zero  (r_offset == '0),
        .o_valid        (f_valid),
        .o_x            (f_x),
        .o_y            (f_y)
    );

    lpt_plane u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (f_valid),
        .i_x      (f_x),
        .i_y      (f_y),
        .i_normal (r_normal),
        .i_offset (r_offset),
        .o_valid  (p_valid),
        .o_ctl    (p_ctl),
        .o_div    (p_div),
        .o_lane   (p_lane)
    );

    lpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (p_valid),
        .i_ctl   (p_ctl),
        .i_div   (p_div),
        .i_lane  (p_lane),
        .o_valid (d_valid),
        .o_ctl   (d_ctl),
        .o_lane  (d_lane)
    );

    always_comb begin
        for (int l = 0; l < lpt_pkg::LANES; l++) begin
            if (d_ctl.par) begin
                if (!d_ctl.nz[l]) begin
                    n_res[l] = '0;
                end else begin
                    n_res[l] = d_ctl.to_max[l] ? lpt_pkg::SAT_MAX : lpt_pkg::SAT_MIN;
                end
            end else if (d_ctl.neg[l]) begin
                if (d_lane[l].ovf || d_lane[l].q > lpt_pkg::Q_W'(lpt_pkg::SAT_MIN)) begin
                    n_res[l] = lpt_pkg::SAT_MIN;
                end else begin
                    n_res[l] = ~d_lane[l].q[lpt_pkg::OUT_W-1:0] + 32'd1;
                end
            end else begin
                if (d_lane[l].ovf || d_lane[l].q > lpt_pkg::Q_W'(lpt_pkg::SAT_MAX)) begin
                    n_res[l] = lpt_pkg::SAT_MAX;
                end else begin
                    n_res[l] = d_lane[l].q[lpt_pkg::OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px     <= n_res[0];
            r_py     <= n_res[1];
            r_pz     <= n_res[2];
            r_status <= d_ctl.par;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_point_z   = r_pz;
    assign o_status    = r_status;
endmodule

// File: hw/rtl/lpt_checker.sv
// Port-level checks for laser_pixel_triangulation, attached by bind.
// Depends on lpt_pkg.
module lpt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [lpt_pkg::OUT_W-1:0]  o_point_x,
    input logic signed [lpt_pkg::OUT_W-1:0]  o_point_y,
    input logic signed [lpt_pkg::OUT_W-1:0]  o_point_z,
    input logic                              o_status
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_point_z) && $stable(o_status))
        else $error("stalled result changed");

    // back-pressure only while a result is held
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall without held result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

    // a parallel ray always saturates depth
    a_parallel_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_point_z == $signed(lpt_pkg::SAT_MAX))
            || (o_point_z == $signed(lpt_pkg::SAT_MIN)))
        else $error("parallel ray with unsaturated z");
endmodule

bind laser_pixel_triangulation lpt_checker u_lpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_point_z   (o_point_z),
    .o_status    (o_status)
);
